[hw/rtl/artdmx_packet_parser_top_macros.svh]
// ----------------------------------------------------------------------------
// ArtDmx parser assertion macros
// Concurrent assertion wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ARTDMX_PACKET_PARSER_TOP_MACROS_SVH
`define ARTDMX_PACKET_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define ADM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ADM_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ADM_ASSERT(label, clk, rst_n, prop, msg)
`define ADM_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

[hw/rtl/artdmx_pkg.sv]
// ----------------------------------------------------------------------------
// ArtDmx parser package
// Widths, header offsets, signature table, codes and the result type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package artdmx_pkg;

  localparam int DMX_SLOTS    = 512;
  localparam int HEADER_BYTES = 18;
  localparam int BUFFER_BYTES = 530;

  localparam int POS_W    = 10;
  localparam int INDEX_W  = 9;
  localparam int COUNT_W  = 10;
  localparam int OPC_W    = 16;
  localparam int UNI_W    = 16;
  localparam int LEN_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int OFS_SIG_END = 8;
  localparam int OFS_OPC_LO  = 8;
  localparam int OFS_OPC_HI  = 9;
  localparam int OFS_SEQ     = 12;
  localparam int OFS_PHYS    = 13;
  localparam int OFS_UNI_LO  = 14;
  localparam int OFS_UNI_HI  = 15;
  localparam int OFS_LEN_HI  = 16;
  localparam int OFS_LEN_LO  = 17;

  localparam logic [7:0] SIG_BYTES [8] = '{
    8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74, 8'h00
  };

  localparam logic [OPC_W-1:0] DMX_OPCODE_RST  = 16'h5000;
  localparam logic [OPC_W-1:0] POLL_OPCODE_RST = 16'h2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DMX_OPCODE  = 1'b0,
    REG_POLL_OPCODE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STAT_DMX    = 2'd0,
    STAT_POLL   = 2'd1,
    STAT_REJECT = 2'd2
  } status_t;

  localparam logic KIND_SLOT    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic               result_kind;
    logic [7:0]         slot_value;
    logic [INDEX_W-1:0] slot_index;
    logic [1:0]         packet_status;
    logic [7:0]         sequence_number;
    logic [7:0]         physical_port;
    logic [UNI_W-1:0]   universe_address;
    logic [COUNT_W-1:0] slot_count;
    logic               run_end;
  } result_t;

endpackage

[hw/rtl/artdmx_in_if.sv]
// ----------------------------------------------------------------------------
// ArtDmx payload byte channel
// Valid/ready channel carrying one UDP payload byte and its last marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface artdmx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

[hw/rtl/artdmx_out_if.sv]
// ----------------------------------------------------------------------------
// ArtDmx result channel
// Valid/ready channel carrying slot bytes and end-of-packet summaries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface artdmx_out_if;
  logic                             valid;
  logic                             ready;
  logic                             result_kind;
  logic [7:0]                       slot_value;
  logic [artdmx_pkg::INDEX_W-1:0]   slot_index;
  logic [1:0]                       packet_status;
  logic [7:0]                       sequence_number;
  logic [7:0]                       physical_port;
  logic [artdmx_pkg::UNI_W-1:0]     universe_address;
  logic [artdmx_pkg::COUNT_W-1:0]   slot_count;
  logic                             run_end;

  modport source (
    output valid, output result_kind, output slot_value, output slot_index,
    output packet_status, output sequence_number, output physical_port,
    output universe_address, output slot_count, output run_end, input ready
  );
  modport sink (
    input valid, input result_kind, input slot_value, input slot_index,
    input packet_status, input sequence_number, input physical_port,
    input universe_address, input slot_count, input run_end, output ready
  );
endinterface

[hw/rtl/artdmx_packet_parser_top.sv]
// ----------------------------------------------------------------------------
// ArtDmx packet parser
// Parses an Art-Net payload byte stream, emits DMX slots and a summary.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one UDP payload byte per beat, last_byte on the final one.
//   out_ch carries results: a slot beat (value and index) for each DMX data
//   byte within the declared count, and one summary beat per packet (status,
//   sequence, physical, universe, slot count). run_end marks the last
//   result of an input beat.
//   cfg_we/cfg_index/cfg_wdata write the ArtDmx and ArtPoll opcodes; write
//   only while the parser is idle.
//   Path: a byte enters an input register, is parsed combinationally from
//   it, and its results go into the result queue that drives out_ch.
//   Throughput: one byte per cycle while the result queue has room. A final
//   byte that also carries a slot yields two result beats and is taken only
//   when the two-entry result queue can hold both.
//   Reset: opcodes return to 0x5000/0x2000, the parser rearms at offset 0,
//   the input register and the result queue empty. When out_ch stalls, the
//   queue fills and in_ch.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "artdmx_packet_parser_top_macros.svh"

module artdmx_packet_parser_top (
  input  logic                              clk,
  input  logic                              rst_n,
  artdmx_in_if.sink                         in_ch,
  artdmx_out_if.source                      out_ch,
  input  logic                              cfg_we,
  input  logic [artdmx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [artdmx_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import artdmx_pkg::*;

  localparam logic [POS_W-1:0] POS_HDR = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_BUF = POS_W'(BUFFER_BYTES);

  logic [OPC_W-1:0] dmx_opc_r, poll_opc_r;

  logic             in_v_r;
  logic [7:0]       in_byte_r;
  logic             in_last_r;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               sig_r, sig_nxt;
  logic [OPC_W-1:0]   opc_r, opc_nxt;
  logic [7:0]         seq_r, seq_nxt;
  logic [7:0]         phys_r, phys_nxt;
  logic [UNI_W-1:0]   uni_r, uni_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [COUNT_W-1:0] sent_r, sent_nxt;

  logic               sig_u;
  logic [OPC_W-1:0]   opc_u;
  logic [7:0]         seq_u, phys_u;
  logic [UNI_W-1:0]   uni_u;
  logic [LEN_W-1:0]   len_u;
  logic [COUNT_W-1:0] sent_u;

  logic [POS_W-1:0] slot;
  logic             is_dmx, emit;
  logic [1:0]       need, rc;
  logic             pop, adv;
  result_t          slot_res, sum_res, e0, e1;

  result_t    q_r [2];
  result_t    q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmx_opc_r  <= DMX_OPCODE_RST;
      poll_opc_r <= POLL_OPCODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DMX_OPCODE:  dmx_opc_r  <= cfg_wdata;
        REG_POLL_OPCODE: poll_opc_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  assign pop         = out_ch.valid && out_ch.ready;
  assign rc          = cnt_r - {1'b0, pop};
  assign adv         = in_v_r && (({1'b0, rc} + {1'b0, need}) <= 3'd2);
  assign in_ch.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.payload_byte;
      in_last_r <= in_ch.last_byte;
    end
  end

  // parse
  always_comb begin
    sig_u  = sig_r;
    opc_u  = opc_r;
    seq_u  = seq_r;
    phys_u = phys_r;
    uni_u  = uni_r;
    len_u  = len_r;

    slot   = pos_r - POS_HDR;
    is_dmx = sig_r && (opc_r != poll_opc_r) && (opc_r == dmx_opc_r);
    emit   = 1'b0;

    if (pos_r < POS_W'(OFS_SIG_END)) begin
      if (in_byte_r != SIG_BYTES[pos_r[2:0]]) sig_u = 1'b0;
    end else if (pos_r == POS_W'(OFS_OPC_LO)) begin
      opc_u = {opc_r[15:8], in_byte_r};
    end else if (pos_r == POS_W'(OFS_OPC_HI)) begin
      opc_u = {in_byte_r, opc_r[7:0]};
    end else if (pos_r == POS_W'(OFS_SEQ)) begin
      seq_u = in_byte_r;
    end else if (pos_r == POS_W'(OFS_PHYS)) begin
      phys_u = in_byte_r;
    end else if (pos_r == POS_W'(OFS_UNI_LO)) begin
      uni_u = {uni_r[15:8], in_byte_r};
    end else if (pos_r == POS_W'(OFS_UNI_HI)) begin
      uni_u = {in_byte_r, uni_r[7:0]};
    end else if (pos_r == POS_W'(OFS_LEN_HI)) begin
      len_u = {in_byte_r, len_r[7:0]};
    end else if (pos_r == POS_W'(OFS_LEN_LO)) begin
      len_u = {len_r[15:8], in_byte_r};
    end else if (pos_r >= POS_HDR && pos_r < POS_BUF) begin
      emit = is_dmx && ({{(LEN_W-POS_W){1'b0}}, slot} < len_r) &&
             ({1'b0, slot} < (POS_W+1)'(DMX_SLOTS));
    end

    sent_u = emit ? sent_r + 1'b1 : sent_r;

    slot_res                  = '0;
    slot_res.result_kind      = KIND_SLOT;
    slot_res.slot_value       = in_byte_r;
    slot_res.slot_index       = slot[INDEX_W-1:0];
    slot_res.packet_status    = STAT_DMX;
    slot_res.run_end          = !in_last_r;

    sum_res                   = '0;
    sum_res.result_kind       = KIND_SUMMARY;
    sum_res.run_end           = 1'b1;
    if (pos_r < POS_W'(HEADER_BYTES - 1) || !sig_u) begin
      sum_res.packet_status = STAT_REJECT;
    end else if (opc_u == poll_opc_r) begin
      sum_res.packet_status = STAT_POLL;
    end else if (opc_u == dmx_opc_r) begin
      sum_res.packet_status    = STAT_DMX;
      sum_res.sequence_number  = seq_u;
      sum_res.physical_port    = phys_u;
      sum_res.universe_address = uni_u;
      sum_res.slot_count       = sent_u;
    end else begin
      sum_res.packet_status = STAT_REJECT;
    end

    need = {1'b0, emit} + {1'b0, in_last_r};
    e0   = emit ? slot_res : sum_res;
    e1   = sum_res;

    if (in_last_r) begin
      pos_nxt  = '0;
      sig_nxt  = 1'b1;
      opc_nxt  = '0;
      seq_nxt  = '0;
      phys_nxt = '0;
      uni_nxt  = '0;
      len_nxt  = '0;
      sent_nxt = '0;
    end else begin
      pos_nxt  = (pos_r < POS_BUF) ? pos_r + 1'b1 : pos_r;
      sig_nxt  = sig_u;
      opc_nxt  = opc_u;
      seq_nxt  = seq_u;
      phys_nxt = phys_u;
      uni_nxt  = uni_u;
      len_nxt  = len_u;
      sent_nxt = sent_u;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sig_r  <= 1'b1;
      opc_r  <= '0;
      seq_r  <= '0;
      phys_r <= '0;
      uni_r  <= '0;
      len_r  <= '0;
      sent_r <= '0;
    end else if (adv) begin
      pos_r  <= pos_nxt;
      sig_r  <= sig_nxt;
      opc_r  <= opc_nxt;
      seq_r  <= seq_nxt;
      phys_r <= phys_nxt;
      uni_r  <= uni_nxt;
      len_r  <= len_nxt;
      sent_r <= sent_nxt;
    end
  end

  // result queue, head at entry 0
  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    cnt_nxt  = rc;
    if (pop) q_nxt[0] = q_r[1];
    if (adv) begin
      cnt_nxt = rc + need;
      if (rc == 2'd0) begin
        q_nxt[0] = e0;
        q_nxt[1] = e1;
      end else if (rc == 2'd1) begin
        q_nxt[1] = e0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_ch.valid            = (cnt_r != 2'd0);
  assign out_ch.result_kind      = q_r[0].result_kind;
  assign out_ch.slot_value       = q_r[0].slot_value;
  assign out_ch.slot_index       = q_r[0].slot_index;
  assign out_ch.packet_status    = q_r[0].packet_status;
  assign out_ch.sequence_number  = q_r[0].sequence_number;
  assign out_ch.physical_port    = q_r[0].physical_port;
  assign out_ch.universe_address = q_r[0].universe_address;
  assign out_ch.slot_count       = q_r[0].slot_count;
  assign out_ch.run_end          = q_r[0].run_end;

  `ADM_NEVER(a_queue_overflow, clk, rst_n, cnt_r > 2'd2, "result queue overflow")
  `ADM_ASSERT(a_rearm_after_last, clk, rst_n, adv && in_last_r |=> pos_r == '0, "no rearm")
  `ADM_NEVER(a_pos_saturates, clk, rst_n, pos_r > POS_BUF, "byte position overrun")
  `ADM_NEVER(a_slots_bounded, clk, rst_n, sent_r > COUNT_W'(DMX_SLOTS), "slot count overrun")
  `ADM_ASSERT(a_two_need_room, clk, rst_n, adv && need == 2'd2 |=> cnt_r == 2'd2, "lost result")

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// ArtDmx packet parser testbench
// Drives Art-Net payload frames into the parser and scores every slot and
// summary beat against an in-bench parse of the same byte stream. A short
// table of hand-built frames comes first, then random frames over four
// opcode settings, the later ones with source gaps, sink stalls or both.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import artdmx_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 300;

  typedef struct packed {
    logic [7:0] b;
    logic       is_last;
    logic       pinned;
    result_t    pinned_beat;
  } stim_row_t;

  localparam result_t SHORT_REJECT = '{KIND_SUMMARY, 8'h00, 9'd0, STAT_REJECT,
                                       8'h00, 8'h00, 16'h0000, 10'd0, 1'b1};
  localparam result_t FIRST_SLOT   = '{KIND_SLOT, 8'hFF, 9'd0, STAT_DMX,
                                       8'h00, 8'h00, 16'h0000, 10'd0, 1'b1};
  localparam result_t DMX_CLOSE    = '{KIND_SUMMARY, 8'h00, 9'd0, STAT_DMX,
                                       8'hFF, 8'h00, 16'hFFFF, 10'd1, 1'b1};

  // single-byte frames, then one ArtDmx frame: seq FF, phys 00, universe FFFF,
  // count 1, two data bytes (second one past the count)
  localparam stim_row_t DIRECTED [23] = '{
    '{8'hFF, 1'b1, 1'b1, SHORT_REJECT},
    '{8'h00, 1'b1, 1'b1, SHORT_REJECT},
    '{8'h41, 1'b1, 1'b1, SHORT_REJECT},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h72, 1'b0, 1'b0, '0},
    '{8'h74, 1'b0, 1'b0, '0},
    '{8'h2D, 1'b0, 1'b0, '0},
    '{8'h4E, 1'b0, 1'b0, '0},
    '{8'h65, 1'b0, 1'b0, '0},
    '{8'h74, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h50, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h0E, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, FIRST_SLOT},
    '{8'h00, 1'b1, 1'b1, DMX_CLOSE}
  };

  localparam int unsigned GAP_BY_PHASE   [4] = '{0, 49, 0, 37};
  localparam int unsigned STALL_BY_PHASE [4] = '{0, 0, 49, 37};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_reg_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  artdmx_in_if  in_ch ();
  artdmx_out_if out_ch ();

  artdmx_packet_parser_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // parser state mirror
  logic [OPC_W-1:0]   dmx_code  = DMX_OPCODE_RST;
  logic [OPC_W-1:0]   poll_code = POLL_OPCODE_RST;
  logic [POS_W-1:0]   at_offset;
  logic               header_ok;
  logic [OPC_W-1:0]   opcode_seen;
  logic [7:0]         seq_seen;
  logic [7:0]         phys_seen;
  logic [UNI_W-1:0]   universe_seen;
  logic [LEN_W-1:0]   length_seen;
  logic [COUNT_W-1:0] slots_out;

  result_t     parsed_results [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned phase_items;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;

  function automatic void rearm();
    at_offset     = '0;
    header_ok     = 1'b1;
    opcode_seen   = '0;
    seq_seen      = '0;
    phys_seen     = '0;
    universe_seen = '0;
    length_seen   = '0;
    slots_out     = '0;
  endfunction

  initial rearm();

  function automatic void parse_byte(input logic [7:0] b, input logic is_last);
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] limit;
    logic [POS_W-1:0] slot;
    result_t          r;
    pos = at_offset;
    if (pos < OFS_SIG_END) begin
      if (b != SIG_BYTES[pos[2:0]]) header_ok = 1'b0;
    end else begin
      case (pos)
        OFS_OPC_LO: opcode_seen[7:0]    = b;
        OFS_OPC_HI: opcode_seen[15:8]   = b;
        OFS_SEQ:    seq_seen            = b;
        OFS_PHYS:   phys_seen           = b;
        OFS_UNI_LO: universe_seen[7:0]  = b;
        OFS_UNI_HI: universe_seen[15:8] = b;
        OFS_LEN_HI: length_seen[15:8]   = b;
        OFS_LEN_LO: length_seen[7:0]    = b;
        default: begin
          if (pos >= HEADER_BYTES && pos < BUFFER_BYTES) begin
            slot  = pos - POS_W'(HEADER_BYTES);
            limit = (length_seen < LEN_W'(DMX_SLOTS)) ? length_seen : LEN_W'(DMX_SLOTS);
            if (header_ok && opcode_seen != poll_code && opcode_seen == dmx_code &&
                LEN_W'(slot) < limit) begin
              r = '0;
              r.result_kind = KIND_SLOT;
              r.slot_value  = b;
              r.slot_index  = slot[INDEX_W-1:0];
              r.run_end     = !is_last;
              parsed_results.push_back(r);
              slots_out = slots_out + 1'b1;
            end
          end
        end
      endcase
    end
    if (pos < BUFFER_BYTES) at_offset = pos + 1'b1;
    if (is_last) begin
      r = '0;
      r.result_kind   = KIND_SUMMARY;
      r.run_end       = 1'b1;
      r.packet_status = STAT_REJECT;
      if (int'(pos) + 1 >= HEADER_BYTES && header_ok) begin
        if (opcode_seen == poll_code) begin
          r.packet_status = STAT_POLL;
        end else if (opcode_seen == dmx_code) begin
          r.packet_status    = STAT_DMX;
          r.sequence_number  = seq_seen;
          r.physical_port    = phys_seen;
          r.universe_address = universe_seen;
          r.slot_count       = slots_out;
        end
      end
      parsed_results.push_back(r);
      rearm();
    end
  endfunction

  // called on a falling edge, returns on the falling edge after acceptance
  task automatic push_byte(input logic [7:0] b, input logic is_last, input logic pinned,
                           input result_t pinned_beat);
    int unsigned n_prior;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.payload_byte <= b;
    in_ch.last_byte    <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    n_prior = parsed_results.size();
    parse_byte(b, is_last);
    if (pinned) begin
      while (parsed_results.size() > n_prior) void'(parsed_results.pop_back());
      parsed_results.push_back(pinned_beat);
    end
    @(negedge clk);
  endtask

  task automatic send_frame(input bit big_one);
    logic [7:0]  frame [$];
    logic [15:0] opc;
    logic [15:0] decl;
    int unsigned kind;
    int unsigned pick;
    int unsigned n_data;
    int unsigned cut;
    kind = big_one ? 0 : $urandom_range(0, 99);
    if (kind >= 89) begin
      // noise
      n_data = $urandom_range(1, 40);
      repeat (n_data) frame.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < 8; i++) frame.push_back(SIG_BYTES[i]);
      if (kind < 55 || kind >= 81) begin
        opc = dmx_code;
      end else if (kind < 65) begin
        opc = poll_code;
      end else if (kind < 73) begin
        opc = $urandom_range(0, 1) ? dmx_code : poll_code;
        cut = $urandom_range(0, 7);
        frame[cut] = frame[cut] ^ 8'($urandom_range(1, 255));
      end else begin
        do opc = 16'($urandom_range(0, 65535));
        while (opc == dmx_code || opc == poll_code);
      end
      pick = $urandom_range(0, 99);
      if (big_one || $urandom_range(0, 99) < 3) begin
        case ($urandom_range(0, 2))
          0:       decl = 16'd512;
          1:       decl = 16'hFFFF;
          default: decl = 16'($urandom_range(513, 1024));
        endcase
        n_data = $urandom_range(507, 522);
      end else begin
        if (pick < 75)      decl = 16'($urandom_range(0, 12));
        else if (pick < 90) decl = 16'($urandom_range(0, 65535));
        else if (pick < 95) decl = 16'h0000;
        else                decl = 16'hFFFF;
        n_data = $urandom_range(0, ((decl < 16'd12) ? int'(decl) : 12) + 3);
      end
      frame.push_back(opc[7:0]);
      frame.push_back(opc[15:8]);
      repeat (6) frame.push_back(8'($urandom_range(0, 255)));
      frame.push_back(decl[15:8]);
      frame.push_back(decl[7:0]);
      repeat (n_data) frame.push_back(8'($urandom_range(0, 255)));
      if (kind >= 81) begin
        cut = $urandom_range(1, HEADER_BYTES - 1);
        while (frame.size() > cut) void'(frame.pop_back());
      end
    end
    foreach (frame[i]) begin
      push_byte(frame[i], i == frame.size() - 1, 1'b0, '0);
      phase_items++;
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (parsed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_opcodes(input logic [OPC_W-1:0] dmx_val,
                                 input logic [OPC_W-1:0] poll_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DMX_OPCODE;
    cfg_wdata <= dmx_val;
    @(posedge clk);
    dmx_code = dmx_val;
    @(negedge clk);
    cfg_index <= REG_POLL_OPCODE;
    cfg_wdata <= poll_val;
    @(posedge clk);
    poll_code = poll_val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : score
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (parsed_results.size() == 0) begin
        $error("result beat with nothing pending");
        mismatches++;
      end else begin
        want = parsed_results.pop_front();
        check_field("result_kind",      16'(want.result_kind),      16'(out_ch.result_kind));
        check_field("slot_value",       16'(want.slot_value),       16'(out_ch.slot_value));
        check_field("slot_index",       16'(want.slot_index),       16'(out_ch.slot_index));
        check_field("packet_status",    16'(want.packet_status),    16'(out_ch.packet_status));
        check_field("sequence_number",  16'(want.sequence_number),  16'(out_ch.sequence_number));
        check_field("physical_port",    16'(want.physical_port),    16'(out_ch.physical_port));
        check_field("universe_address", want.universe_address,      out_ch.universe_address);
        check_field("slot_count",       16'(want.slot_count),       16'(out_ch.slot_count));
        check_field("run_end",          16'(want.run_end),          16'(out_ch.run_end));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    bit first_frame;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_DMX_OPCODE;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.payload_byte = '0;
    in_ch.last_byte    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i])
      push_byte(DIRECTED[i].b, DIRECTED[i].is_last, DIRECTED[i].pinned,
                DIRECTED[i].pinned_beat);

    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        1: program_opcodes(16'hFFFF, 16'h0000);
        2: program_opcodes(16'h0000, 16'h0000);
        3: program_opcodes(16'($urandom_range(0, 65535)), 16'hFFFF);
        default: ;
      endcase
      gap_pct     = GAP_BY_PHASE[p];
      stall_pct   = STALL_BY_PHASE[p];
      phase_items = 0;
      first_frame = (p == 0);
      while (phase_items < PHASE_ITEMS) begin
        send_frame(first_frame);
        first_frame = 1'b0;
      end
    end
    settle();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/artdmx_pkg.sv
hw/rtl/artdmx_in_if.sv
hw/rtl/artdmx_out_if.sv
hw/rtl/artdmx_packet_parser_top.sv
tb/sv/testbench.sv
